### sv/csfp_pkg.sv
// Shared types and constants for the cycling speed-from-power core.
// Used by csfp_div and cycling_speed_from_power_core; depends on nothing.
package csfp_pkg;

   localparam int SPEED_FRAC_BITS_DEF = 10;

   // Serial divider sizing: left-aligned numerator, one quotient bit a cycle
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = 7;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] count;   // numerator bits to process
   } div_req_type;

   typedef enum logic [1:0] {
      CSR_DIRECT = 2'd0,
      CSR_MASS   = 2'd1,
      CSR_CORR   = 2'd2
   } csr_index_type;

endpackage

### sv/csfp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on csfp_pkg.
module csfp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  csfp_pkg::div_req_type             div_req,
   input  logic [csfp_pkg::DIV_NUM_W-1:0]    numer,    // left-aligned in count bits
   input  logic [csfp_pkg::DIV_DEN_W-1:0]    denom,
   output logic                              div_done,
   output logic [csfp_pkg::DIV_NUM_W-1:0]    quot
);
   import csfp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.count;
         num_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         // quotient bits shift in at the bottom as numerator bits leave the top
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DIV_DEN_W-1:0];
            num_in = {num_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_done = done_ff;
   assign quot     = num_ff;

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("divider launched while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while still busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && den_ff != '0) |-> rem_ff < den_ff) else $error("remainder out of range");
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == DIV_CNT_W'(1) && !div_req.start) |=> done_ff)
      else $error("missing done");

endmodule

### sv/cycling_speed_from_power_core.sv
// Cycling speed-from-power core: one result transfer per input transfer. A restart,
// a direct-mode tick, or a no-power tick below half speed or past the idle limit skips
// the divider. A power-model tick runs three or four divisions on one shared bit-serial
// divider (rolling resistance 32 bits, gravity 43, drive force 25+SPEED_FRAC_BITS only
// above the drive speed limit, speed change 48+SPEED_FRAC_BITS; 10 fraction bits by
// default) plus control states. That divider sets the rate. A new item is taken while
// the previous result still waits in the output register.
// Depends on csfp_pkg and csfp_div.
module cycling_speed_from_power_core #(
   parameter int SPEED_FRAC_BITS = csfp_pkg::SPEED_FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // elapsed_ms[15:0], power_watts[27:16], slope_grade[40:28], wheel_speed[56:41],
   // start_distance[88:57], zero fill
   input  logic [95:0]  req_tdata,
   // action[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // speed[15:0], distance_mm[47:16], travelled_mm[79:48], run_time_ms[111:80],
   // idle_stopped[112], zero fill
   output logic [119:0] rsp_tdata
);
   import csfp_pkg::*;

   localparam int F = SPEED_FRAC_BITS;
   localparam logic [16:0] HALF_SPEED = 17'(2 ** (F - 1));
   localparam logic [19:0] DRIVE_LIM  = 20'(4 * (2 ** F));
   localparam int DRAG_SHIFT = 4 + 2 * F;
   localparam int N_ROLL  = 32;
   localparam int N_GRAV  = 43;
   localparam int N_DRIVE = 25 + F;
   localparam int N_DV    = 48 + F;
   localparam logic [31:0] ROLL_K   = 32'd1004544;
   localparam logic [31:0] ROLL_DIV = 32'd100000;
   localparam logic [31:0] GRAV_DIV = 32'd1000000;
   localparam logic [34:0] GRAV_K   = 35'd981;
   localparam logic [45:0] DRAG_K   = 46'd14679;
   localparam logic [29:0] DEN_K    = 30'd256000;
   localparam logic [15:0] IDLE_LIM = 16'd5000;
   localparam logic [24:0] P_IDLE   = 25'd4096;

   typedef enum logic [11:0] {
      S_IDLE   = 12'h001,
      S_PREP   = 12'h002,
      S_DECIDE = 12'h004,
      S_DROLL  = 12'h008,
      S_DGRAV  = 12'h010,
      S_DDRIVE = 12'h020,
      S_NET    = 12'h040,
      S_SCALE  = 12'h080,
      S_DDV    = 12'h100,
      S_MM     = 12'h200,
      S_ADD    = 12'h400,
      S_FIN    = 12'h800
   } state_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   state_type state_ff, state_in;

   logic        direct_ff, direct_in;
   logic [11:0] mass_cfg_ff, mass_cfg_in;
   logic [12:0] corr_ff, corr_in;

   logic [15:0] cur_ff, cur_in;
   logic [31:0] route_ff, route_in, covered_ff, covered_in, moving_ff, moving_in;
   logic [15:0] idle_ff, idle_in;

   logic        act_ff, act_in;
   logic [15:0] el_ff, el_in;
   logic [11:0] pw_ff, pw_in;
   logic [12:0] slope_ff, slope_in;
   logic [15:0] wheel_ff, wheel_in;
   logic [31:0] start_ff, start_in;

   logic [24:0] p_ff, p_in;
   logic [11:0] mass_ff, mass_in;
   logic [31:0] spd2_ff, spd2_in;
   logic [24:0] sm_ff, sm_in;
   logic        gneg_ff, gneg_in;
   logic [29:0] den_ff, den_in;
   logic [34:0] gm_ff, gm_in;
   logic [31:0] drag_ff, drag_in;
   logic [15:0] roll_ff, roll_in;
   logic [22:0] grav_ff, grav_in;
   logic [26:0] drive_ff, drive_in;
   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic [47:0] prod_ff, prod_in;
   logic [15:0] spd_ff, spd_in;
   logic        stop_ff, stop_in;
   logic [31:0] mm_ff, mm_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [119:0] rsp_data_ff, rsp_data_in;

   div_req_type          div_req;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] quot;

   // combinational helpers
   logic [12:0]        factor;
   logic [11:0]        mass_eff;
   logic [12:0]        slope_mag;
   logic [45:0]        drag_full;
   logic [16:0]        idle_sum;
   logic [15:0]        idle_sat;
   logic [19:0]        cur_x10;
   logic signed [33:0] grav_s, net;
   logic [33:0]        net_mag;
   logic [16:0]        dv_lo;
   logic               dv_big;
   logic [17:0]        up;
   logic [16:0]        res;
   logic [31:0]        mm_full;

   csfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .numer    (div_num),
      .denom    (div_den),
      .div_done (div_done),
      .quot     (quot)
   );

   // Launch the divider on entry to a divide state; operands come from registers,
   // except the speed-change product, which is formed in the launch cycle
   always_comb begin
      div_req.start = (state_in != state_ff) &&
                      (state_in == S_DROLL || state_in == S_DGRAV ||
                       state_in == S_DDRIVE || state_in == S_DDV);
      div_req.count = DIV_CNT_W'(N_ROLL);
      div_num       = 64'(32'(mass_ff) * ROLL_K) << (DIV_NUM_W - N_ROLL);
      div_den       = ROLL_DIV;
      priority case (1'b1)
         state_in == S_DGRAV: begin
            div_req.count = DIV_CNT_W'(N_GRAV);
            div_num       = 64'({gm_ff, 8'b0}) << (DIV_NUM_W - N_GRAV);
            div_den       = GRAV_DIV;
         end
         state_in == S_DDRIVE: begin
            div_req.count = DIV_CNT_W'(N_DRIVE);
            div_num       = 64'(p_ff) << (DIV_NUM_W - 25);
            div_den       = 32'(cur_ff);
         end
         state_in == S_DDV: begin
            div_req.count = DIV_CNT_W'(N_DV);
            div_num       = 64'(prod_in) << (DIV_NUM_W - 48);
            div_den       = 32'(den_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      factor    = {~corr_ff[12], corr_ff[11:0]};   // 4096 + signed correction
      mass_eff  = (mass_cfg_ff == '0) ? 12'd1 : mass_cfg_ff;
      slope_mag = slope_ff[12] ? (~slope_ff + 13'd1) : slope_ff;
      drag_full = 46'(spd2_ff) * DRAG_K;
      idle_sum  = {1'b0, idle_ff} + {1'b0, el_ff};
      idle_sat  = idle_sum[16] ? 16'hFFFF : idle_sum[15:0];
      cur_x10   = 20'(cur_ff) * 20'd10;
      grav_s    = gneg_ff ? -$signed({11'b0, grav_ff}) : $signed({11'b0, grav_ff});
      net       = $signed({7'b0, drive_ff}) - $signed({2'b0, drag_ff}) - grav_s
                  - $signed({18'b0, roll_ff});
      net_mag   = net[33] ? 34'(-net) : 34'(net);
      dv_lo     = quot[16:0];
      dv_big    = |quot[DIV_NUM_W-1:17];
      up        = 18'(cur_ff) + 18'(dv_lo);
      if (neg_ff) begin
         res = (dv_big || dv_lo >= {1'b0, cur_ff}) ? 17'd0 : {1'b0, cur_ff} - dv_lo;
      end else begin
         res = (dv_big || up > 18'h0FFFF) ? 17'h0FFFF : up[16:0];
      end
      if (res < HALF_SPEED) begin
         res = HALF_SPEED;
      end
      mm_full = 32'(spd_ff) * 32'(el_ff);
   end

   always_comb begin
      state_in     = state_ff;
      direct_in    = direct_ff;
      mass_cfg_in  = mass_cfg_ff;
      corr_in      = corr_ff;
      cur_in       = cur_ff;
      route_in     = route_ff;
      covered_in   = covered_ff;
      moving_in    = moving_ff;
      idle_in      = idle_ff;
      act_in       = act_ff;
      el_in        = el_ff;
      pw_in        = pw_ff;
      slope_in     = slope_ff;
      wheel_in     = wheel_ff;
      start_in     = start_ff;
      p_in         = p_ff;
      mass_in      = mass_ff;
      spd2_in      = spd2_ff;
      sm_in        = sm_ff;
      gneg_in      = gneg_ff;
      den_in       = den_ff;
      gm_in        = gm_ff;
      drag_in      = drag_ff;
      roll_in      = roll_ff;
      grav_in      = grav_ff;
      drive_in     = drive_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      spd_in       = spd_ff;
      stop_in      = stop_ff;
      mm_in        = mm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_DIRECT: direct_in   = csr_wdata[0];
            CSR_MASS:   mass_cfg_in = csr_wdata[11:0];
            CSR_CORR:   corr_in     = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in   = req_tuser;
               el_in    = req_tdata[15:0];
               pw_in    = req_tdata[27:16];
               slope_in = req_tdata[40:28];
               wheel_in = req_tdata[56:41];
               start_in = req_tdata[88:57];
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            p_in     = 25'(pw_ff) * 25'(factor);
            mass_in  = mass_eff;
            spd2_in  = 32'(cur_ff) * 32'(cur_ff);
            sm_in    = 25'(slope_mag) * 25'(mass_eff);
            gneg_in  = slope_ff[12];
            den_in   = 30'(mass_eff) * DEN_K;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            gm_in   = 35'(sm_ff) * GRAV_K;
            drag_in = 32'(drag_full >> DRAG_SHIFT);
            spd_in  = '0;
            stop_in = 1'b0;
            if (act_ff) begin
               cur_in     = '0;
               route_in   = start_ff;
               covered_in = '0;
               moving_in  = '0;
               state_in   = S_FIN;
            end else begin
               if (cur_ff != '0) begin
                  moving_in = sat_add(moving_ff, 32'(el_ff));
               end
               if (direct_ff) begin
                  spd_in   = wheel_ff;
                  state_in = S_MM;
               end else if (p_ff < P_IDLE) begin
                  if ({1'b0, cur_ff} < HALF_SPEED) begin
                     state_in = S_MM;
                  end else begin
                     idle_in = idle_sat;
                     if (idle_sat > IDLE_LIM) begin
                        stop_in  = 1'b1;
                        state_in = S_MM;
                     end else begin
                        state_in = S_DROLL;
                     end
                  end
               end else begin
                  idle_in  = '0;
                  state_in = S_DROLL;
               end
            end
         end
         S_DROLL: begin
            if (div_done) begin
               roll_in  = quot[15:0];
               state_in = S_DGRAV;
            end
         end
         S_DGRAV: begin
            if (div_done) begin
               grav_in = quot[22:0];
               if (cur_x10 > DRIVE_LIM) begin
                  state_in = S_DDRIVE;
               end else begin
                  drive_in = 27'({mass_ff, 8'b0});
                  state_in = S_NET;
               end
            end
         end
         S_DDRIVE: begin
            if (div_done) begin
               drive_in = quot[26:0];
               state_in = S_NET;
            end
         end
         S_NET: begin
            neg_in   = net[33];
            mag_in   = net_mag[31:0];
            state_in = S_SCALE;
         end
         S_SCALE: begin
            prod_in  = 48'(mag_ff) * 48'(el_ff);
            state_in = S_DDV;
         end
         S_DDV: begin
            if (div_done) begin
               spd_in   = res[15:0];
               state_in = S_MM;
            end
         end
         S_MM: begin
            mm_in    = mm_full >> F;
            cur_in   = spd_ff;
            state_in = S_ADD;
         end
         S_ADD: begin
            route_in   = sat_add(route_ff, mm_ff);
            covered_in = sat_add(covered_ff, mm_ff);
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, stop_ff, moving_ff, covered_ff, route_ff, cur_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         direct_ff    <= 1'b0;
         mass_cfg_ff  <= 12'd1280;
         corr_ff      <= '0;
         cur_ff       <= '0;
         route_ff     <= '0;
         covered_ff   <= '0;
         moving_ff    <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         direct_ff    <= direct_in;
         mass_cfg_ff  <= mass_cfg_in;
         corr_ff      <= corr_in;
         cur_ff       <= cur_in;
         route_ff     <= route_in;
         covered_ff   <= covered_in;
         moving_ff    <= moving_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      el_ff       <= el_in;
      pw_ff       <= pw_in;
      slope_ff    <= slope_in;
      wheel_ff    <= wheel_in;
      start_ff    <= start_in;
      p_ff        <= p_in;
      mass_ff     <= mass_in;
      spd2_ff     <= spd2_in;
      sm_ff       <= sm_in;
      gneg_ff     <= gneg_in;
      den_ff      <= den_in;
      gm_ff       <= gm_in;
      drag_ff     <= drag_in;
      roll_ff     <= roll_in;
      grav_ff     <= grav_in;
      drive_ff    <= drive_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      spd_ff      <= spd_in;
      stop_ff     <= stop_in;
      mm_ff       <= mm_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_idle_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[112]) |-> rsp_tdata[15:0] == '0)
      else $error("idle stop with nonzero speed");
   a_speed_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_tvalid) |=> $stable(cur_ff))
      else $error("speed changed while idle");
   a_speed_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DDV && div_done) |-> {1'b0, spd_in} >= HALF_SPEED)
      else $error("power-model speed below floor");

endmodule

### test/tb_top.sv
// Testbench for cycling_speed_from_power_core: random and directed ticks, restarts
// and register settings, checked against an in-bench speed and distance predictor.
// Depends on csfp_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
   import csfp_pkg::*;

   localparam int FB = 10;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic        action;
      logic [15:0] elapsed_ms;
      logic [11:0] power_watts;
      logic [12:0] slope_grade;
      logic [15:0] wheel_speed;
      logic [31:0] start_distance;
   } tick_t;

   typedef struct packed {
      logic [15:0] speed;
      logic [31:0] distance_mm;
      logic [31:0] travelled_mm;
      logic [31:0] run_time_ms;
      logic        idle_stopped;
   } ride_t;

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_we = 0;
   logic [1:0]   csr_index = CSR_DIRECT;
   logic [12:0]  csr_wdata = 0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [95:0]  req_tdata = 0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [119:0] rsp_tdata;

   cycling_speed_from_power_core dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   tick_t  tick_queue[$];
   ride_t  ride_expect[$];
   int     errors = 0;
   bit     quiet_req = 0, quiet_rsp = 0;
   bit     rsp_holdoff = 0;
   int     idle_cycles = 0;
   bit     req_tready_seen = 0;

   // predictor state
   bit          m_direct;
   logic [11:0] m_mass;
   logic [12:0] m_corr;
   logic [15:0] v_speed, v_idle;
   logic [31:0] v_dist, v_cov, v_run;

   function automatic logic [31:0] sat_add(logic [31:0] a, longint unsigned b);
      longint unsigned s;
      s = longint'(a) + b;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [15:0] model_speed(longint unsigned p4096,
                                               longint slope, longint unsigned el);
      longint unsigned s1, spd, mass, mag, dv, res;
      longint drive, drag, grav, roll, net, gp;
      s1 = 64'd1 << FB;
      spd = v_speed;
      mass = (m_mass == 0) ? 1 : m_mass;
      if (spd * 10 > 4 * s1) drive = p4096 * s1 / spd;
      else drive = mass * 256;
      drag = (64'd14679 * spd * spd) >> (4 + 2 * FB);
      gp = slope * longint'(mass) * 981 * 256;
      if (gp < 0) grav = -longint'(unsigned'(-gp) / 1000000);
      else grav = unsigned'(gp) / 1000000;
      roll = mass * 1004544 / 100000;
      net = drive - drag - grav - roll;
      mag = (net < 0) ? -net : net;
      dv = mag * el * s1 / (256000 * mass);
      if (net < 0) res = (dv >= spd) ? 0 : spd - dv;
      else res = spd + dv;
      if (res < s1 / 2) res = s1 / 2;
      if (res > 16'hFFFF) res = 16'hFFFF;
      return res[15:0];
   endfunction

   function automatic ride_t predict_ride(tick_t t);
      ride_t r;
      longint unsigned p4096, mm, ti;
      logic [15:0] spd;
      bit run;
      r.idle_stopped = 0;
      if (t.action) begin
         v_speed = 0; v_dist = t.start_distance; v_cov = 0; v_run = 0;
      end else begin
         if (v_speed != 0) v_run = sat_add(v_run, t.elapsed_ms);
         if (m_direct) spd = t.wheel_speed;
         else begin
            p4096 = longint'(t.power_watts) * (4096 + longint'($signed(m_corr)));
            run = 1;
            spd = 0;
            if (p4096 < 4096) begin
               if (v_speed * 2 < (1 << FB)) run = 0;
               else begin
                  ti = v_idle + t.elapsed_ms;
                  v_idle = (ti > 16'hFFFF) ? 16'hFFFF : ti[15:0];
                  if (v_idle > 5000) begin
                     run = 0;
                     r.idle_stopped = 1;
                  end
               end
            end else v_idle = 0;
            if (run) spd = model_speed(p4096, $signed(t.slope_grade), t.elapsed_ms);
         end
         mm = (longint'(spd) * t.elapsed_ms) >> FB;
         v_speed = spd;
         v_dist = sat_add(v_dist, mm);
         v_cov = sat_add(v_cov, mm);
      end
      r.speed = v_speed; r.distance_mm = v_dist;
      r.travelled_mm = v_cov; r.run_time_ms = v_run;
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (tick_queue.size() != 0 && (quiet_req || $urandom_range(99) >= 29)) begin
               tick_t t;
               t = tick_queue.pop_front();
               req_tvalid <= 1;
               req_tuser <= t.action;
               req_tdata <= {7'd0, t.start_distance, t.wheel_speed, t.slope_grade,
                             t.power_watts, t.elapsed_ms};
            end else req_tvalid <= 0;
         end
         rsp_tready <= !rsp_holdoff && (quiet_rsp || $urandom_range(99) >= 29);
      end
   end

   // monitor: predict on accepted input, compare on accepted output
   always @(posedge clock) begin
      bit moved;
      moved = 0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tick_t t;
            t.action = req_tuser;
            {t.start_distance, t.wheel_speed, t.slope_grade, t.power_watts,
             t.elapsed_ms} = req_tdata[88:0];
            ride_expect.push_back(predict_ride(t));
            moved = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            ride_t got, want;
            moved = 1;
            got = {rsp_tdata[15:0], rsp_tdata[47:16], rsp_tdata[79:48],
                   rsp_tdata[111:80], rsp_tdata[112]};
            if (ride_expect.size() == 0) begin
               $error("result transfer with no expectation");
               errors++;
            end else begin
               want = ride_expect.pop_front();
               if (got.speed !== want.speed) begin
                  $error("speed exp %0d got %0d", want.speed, got.speed); errors++;
               end
               if (got.distance_mm !== want.distance_mm) begin
                  $error("distance_mm exp %0d got %0d", want.distance_mm,
                         got.distance_mm); errors++;
               end
               if (got.travelled_mm !== want.travelled_mm) begin
                  $error("travelled_mm exp %0d got %0d", want.travelled_mm,
                         got.travelled_mm); errors++;
               end
               if (got.run_time_ms !== want.run_time_ms) begin
                  $error("run_time_ms exp %0d got %0d", want.run_time_ms,
                         got.run_time_ms); errors++;
               end
               if (got.idle_stopped !== want.idle_stopped) begin
                  $error("idle_stopped exp %0d got %0d", want.idle_stopped,
                         got.idle_stopped); errors++;
               end
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
      req_tready_seen <= !reset && req_tvalid && req_tready;
   end

   task automatic write_reg(csr_index_type idx, logic [12:0] val);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         CSR_DIRECT: m_direct = val[0];
         CSR_MASS:   m_mass = val[11:0];
         default:    m_corr = val;
      endcase
   endtask

   task automatic drain;
      while (tick_queue.size() != 0 || req_tvalid || ride_expect.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic tick_t make_tick(int act, int el, int pw, int sl, int wh,
                                       logic [31:0] sd);
      tick_t t;
      t.action = 1'(act); t.elapsed_ms = 16'(el); t.power_watts = 12'(pw);
      t.slope_grade = 13'(sl); t.wheel_speed = 16'(wh); t.start_distance = sd;
      return t;
   endfunction

   function automatic tick_t rand_tick();
      tick_t t;
      int r;
      r = $urandom_range(99);
      t.action = (r < 4);
      t.elapsed_ms = (r < 10) ? 16'($urandom) : 16'($urandom_range(1, 200));
      t.power_watts = (r < 20) ? 12'($urandom_range(0, 2)) :
                      (r < 30) ? 12'($urandom) : 12'($urandom_range(50, 600));
      t.slope_grade = 13'(int'($urandom_range(0, 8000)) - 4000);
      t.wheel_speed = 16'($urandom);
      t.start_distance = (r < 2) ? 32'hFFFF_F000 + $urandom_range(4095) : $urandom;
      return t;
   endfunction

   initial begin
      m_direct = 0; m_mass = 1280; m_corr = 0;
      v_speed = 0; v_dist = 0; v_cov = 0; v_run = 0; v_idle = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_reg(CSR_DIRECT, 13'd0);
      write_reg(CSR_MASS, 13'd1280);
      write_reg(CSR_CORR, 13'd0);
      // directed: stopped with no power, start, restarts, extremes, idle timeout
      tick_queue.push_back(make_tick(0, 100, 0, 0, 0, 0));
      tick_queue.push_back(make_tick(0, 100, 4095, 4000, 65535, 0));
      tick_queue.push_back(make_tick(0, 65535, 4095, -4000, 0, 0));
      tick_queue.push_back(make_tick(0, 0, 200, 0, 0, 0));
      tick_queue.push_back(make_tick(0, 3000, 0, 0, 0, 0));
      tick_queue.push_back(make_tick(0, 3000, 0, 0, 0, 0));
      tick_queue.push_back(make_tick(0, 100, 0, 0, 0, 0));
      tick_queue.push_back(make_tick(1, 0, 0, 0, 0, 32'hFFFF_FFFF));
      tick_queue.push_back(make_tick(0, 65535, 4095, -4000, 0, 0));
      tick_queue.push_back(make_tick(0, 65535, 4095, -4000, 0, 0));
      tick_queue.push_back(make_tick(1, 0, 0, 0, 0, 0));
      tick_queue.push_back(make_tick(0, 1000, 300, 2000, 0, 0));
      drain();
      write_reg(CSR_DIRECT, 13'd1);
      tick_queue.push_back(make_tick(0, 65535, 0, 0, 65535, 0));
      tick_queue.push_back(make_tick(0, 500, 0, 0, 0, 0));
      tick_queue.push_back(make_tick(0, 500, 0, 0, 12345, 0));
      drain();
      write_reg(CSR_DIRECT, 13'd0);
      write_reg(CSR_MASS, 13'd4095);
      write_reg(CSR_CORR, 13'(-2048));
      tick_queue.push_back(make_tick(0, 200, 1, 0, 0, 0));
      tick_queue.push_back(make_tick(0, 200, 2, 4000, 0, 0));
      tick_queue.push_back(make_tick(0, 200, 4095, -4000, 0, 0));
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            1: begin write_reg(CSR_MASS, 13'd160); write_reg(CSR_CORR, 13'd4095); end
            2: write_reg(CSR_DIRECT, 13'd1);
            3: begin write_reg(CSR_DIRECT, 13'd0); write_reg(CSR_MASS, 13'd0); end
            4: begin write_reg(CSR_MASS, 13'd1280); write_reg(CSR_CORR, 13'd0); end
            5: write_reg(CSR_CORR, 13'(-2048));
            6: begin write_reg(CSR_MASS, 13'($urandom_range(160, 4095)));
                      write_reg(CSR_CORR, 13'($urandom)); end
            7: write_reg(CSR_MASS, 13'd4095);
            default: ;
         endcase
         quiet_req = (ph == 4); quiet_rsp = (ph == 4);
         for (int i = 0; i < 235; i++) tick_queue.push_back(rand_tick());
         if (ph == 5) begin
            // receiver holds off while the sender keeps offering
            rsp_holdoff = 1;
            repeat (2000) @(posedge clock);
            rsp_holdoff = 0;
         end
         drain();
      end
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
